// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the cipher block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

// ----- sv/lakfc_pkg.sv -----
// ---------------------------------------------------------------------------
// lakfc_pkg
// Types and constants of the letter-armored key-feedback cipher.
// ---------------------------------------------------------------------------
package lakfc_pkg;

	// Field widths
	localparam int BYTE_W     = 8;
	localparam int KEY_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_KEY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LETTER_BASE = 2'd2;

	// Direction codes
	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	// Reset values
	localparam logic [KEY_W-1:0]  KEY_RESET  = 16'd8314;
	localparam logic [BYTE_W-1:0] BASE_RESET = 8'd65;

	// Key update: (cipher + key) * 92845 + 72719, kept mod 2^16
	localparam int KEY_MUL = 92845;
	localparam int KEY_ADD = 72719;
	localparam logic [KEY_W-1:0] KEY_MUL_LO = KEY_W'(KEY_MUL % (1 << KEY_W));
	localparam logic [KEY_W-1:0] KEY_ADD_LO = KEY_W'(KEY_ADD % (1 << KEY_W));

	// Base-26 digits; quotient by reciprocal multiply, exact for 0..255
	localparam logic [BYTE_W-1:0] DIGIT_RADIX = 8'd26;
	localparam int RECIP_SHIFT = 12;
	localparam logic [2*BYTE_W-1:0] RECIP_MUL =
		(2*BYTE_W)'(((1 << RECIP_SHIFT) + 26 - 1) / 26);

	// Control from the pipeline to the key register
	typedef struct packed {
		logic advance;
		logic start;
	} key_ctrl_t;

endpackage

// ----- sv/lakfc_if.sv -----
// ---------------------------------------------------------------------------
// lakfc_if
// Valid/ready channels of the cipher: input items, results, register writes.
// ---------------------------------------------------------------------------
interface lakfc_in_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [7:0] data_a;
	logic [7:0] data_b;

	modport source (output valid, output start_req, output data_a, output data_b,
		input ready);
	modport sink (input valid, input start_req, input data_a, input data_b,
		output ready);
endinterface

interface lakfc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_first;
	logic [7:0] out_second;

	modport source (output valid, output out_first, output out_second, input ready);
	modport sink (input valid, input out_first, input out_second, output ready);
endinterface

interface lakfc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/lakfc_codec.sv -----
// ---------------------------------------------------------------------------
// lakfc_codec
// Masks a byte and splits it into two letters, or folds a letter pair back
// into a cipher byte and unmasks it.
// ---------------------------------------------------------------------------
module lakfc_codec (
	input  logic                        direction,
	input  logic [lakfc_pkg::BYTE_W-1:0] letter_base,
	input  logic [lakfc_pkg::BYTE_W-1:0] mask,
	input  logic [lakfc_pkg::BYTE_W-1:0] data_a,
	input  logic [lakfc_pkg::BYTE_W-1:0] data_b,
	output logic [lakfc_pkg::BYTE_W-1:0] cipher,
	output logic [lakfc_pkg::BYTE_W-1:0] out_first,
	output logic [lakfc_pkg::BYTE_W-1:0] out_second
);
	import lakfc_pkg::*;

	logic [BYTE_W-1:0]   enc_cipher;
	logic [2*BYTE_W-1:0] recip_prod;
	logic [2*BYTE_W-1:0] recip_shifted;
	logic [BYTE_W-1:0]   digit_hi;
	logic [BYTE_W-1:0]   digit_lo;
	logic [BYTE_W-1:0]   diff_a;
	logic [BYTE_W-1:0]   diff_b;
	logic [BYTE_W-1:0]   dec_cipher;

	// Encrypt: mask, then quotient and remainder by 26
	always_comb begin
		enc_cipher    = data_a ^ mask;
		recip_prod    = {{BYTE_W{1'b0}}, enc_cipher} * RECIP_MUL;
		recip_shifted = recip_prod >> RECIP_SHIFT;
		digit_hi      = recip_shifted[BYTE_W-1:0];
		digit_lo      = enc_cipher - BYTE_W'(digit_hi * DIGIT_RADIX);
	end

	// Decrypt: fold the letter pair, wrapping mod 256
	always_comb begin
		diff_a     = data_a - letter_base;
		diff_b     = data_b - letter_base;
		dec_cipher = BYTE_W'(diff_a * DIGIT_RADIX) + diff_b;
	end

	// Select by direction
	always_comb begin
		unique case (direction)
			DIR_ENCRYPT: begin
				cipher     = enc_cipher;
				out_first  = letter_base + digit_hi;
				out_second = letter_base + digit_lo;
			end
			default: begin
				cipher     = dec_cipher;
				out_first  = dec_cipher ^ mask;
				out_second = '0;
			end
		endcase
	end

endmodule

// ----- sv/lakfc_key_unit.sv -----
// ---------------------------------------------------------------------------
// lakfc_key_unit
// Running key register with seed reload and ciphertext feedback update.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lakfc_key_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lakfc_pkg::key_ctrl_t         ctrl,
	input  logic [lakfc_pkg::KEY_W-1:0]  seed_key,
	input  logic [lakfc_pkg::BYTE_W-1:0] cipher,
	output logic [lakfc_pkg::BYTE_W-1:0] mask
);
	import lakfc_pkg::*;

	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   key_eff;
	logic [KEY_W-1:0]   key_sum;
	logic [2*KEY_W-1:0] key_prod;
	logic [KEY_W-1:0]   key_next;

	// Reload from the seed at the start of a string
	assign key_eff = ctrl.start ? seed_key : key_q;
	assign mask    = key_eff[KEY_W-1:KEY_W-BYTE_W];

	// Next key from the cipher byte, low 16 bits only
	always_comb begin
		key_sum  = key_eff + {{(KEY_W-BYTE_W){1'b0}}, cipher};
		key_prod = {{KEY_W{1'b0}}, key_sum} * {{KEY_W{1'b0}}, KEY_MUL_LO};
		key_next = key_prod[KEY_W-1:0] + KEY_ADD_LO;
	end

	// Advance the key once per transaction that leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_RESET;
		end else if (ctrl.advance) begin
			key_q <= key_next;
		end
	end

	`ASSERT_HOLDS(a_key_holds, clk, arst_n,
		!ctrl.advance |=> $stable(key_q), "key moved without an item")
	`ASSERT_HOLDS(a_key_update, clk, arst_n,
		ctrl.advance |=> key_q == $past(key_next), "key update lost")
	`ASSERT_NEVER(a_start_known, clk, arst_n,
		ctrl.advance && $isunknown(ctrl.start), "start flag unknown on advance")

endmodule

// ----- sv/letter_armored_key_feedback_cipher.sv -----
// ---------------------------------------------------------------------------
// letter_armored_key_feedback_cipher
// Byte stream cipher with a ciphertext-fed 16-bit key and letter armoring.
// ---------------------------------------------------------------------------
//  channel | dir | payload                          | transaction
//  req     | in  | start_req, data_a, data_b        | req.valid && req.ready
//  rsp     | out | out_first, out_second            | rsp.valid && rsp.ready
//  cfg     | in  | index (2b), data (16b)           | cfg.valid && cfg.ready
//
//  One item per cycle while rsp is not stalled; each result passes the input
//  stage and the result register before it is on rsp.
//  The key register's feedback path is combinational: mask, cipher, one
//  16x16 multiply-add. cfg is always ready and writes take effect at once.
//  arst_n clears the pipeline, the key (8314) and the registers.
//  A stalled rsp holds its result while one more item waits in the input stage.
`include "assert_macros.svh"

module letter_armored_key_feedback_cipher (
	input  logic         clk,
	input  logic         arst_n,
	lakfc_in_if.sink     req,
	lakfc_out_if.source  rsp,
	lakfc_cfg_if.sink    cfg
);
	import lakfc_pkg::*;

	// Configuration registers
	logic              direction_q;
	logic [KEY_W-1:0]  seed_key_q;
	logic [BYTE_W-1:0] letter_base_q;

	// Input stage
	logic              valid_s1;
	logic              start_s1;
	logic [BYTE_W-1:0] data_a_s1;
	logic [BYTE_W-1:0] data_b_s1;

	// Result stage
	logic              valid_s2;
	logic [BYTE_W-1:0] first_s2;
	logic [BYTE_W-1:0] second_s2;

	logic              advance;
	key_ctrl_t         key_ctrl;
	logic [BYTE_W-1:0] mask;
	logic [BYTE_W-1:0] cipher;
	logic [BYTE_W-1:0] res_first;
	logic [BYTE_W-1:0] res_second;

	// Write configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q   <= DIR_ENCRYPT;
			seed_key_q    <= KEY_RESET;
			letter_base_q <= BASE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DIRECTION:   direction_q   <= cfg.data[0];
				REG_SEED_KEY:    seed_key_q    <= cfg.data[KEY_W-1:0];
				REG_LETTER_BASE: letter_base_q <= cfg.data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Move the input stage forward when the result register is free or drains
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			start_s1  <= req.start_req;
			data_a_s1 <= req.data_a;
			data_b_s1 <= req.data_b;
		end
	end

	// Key register and cipher datapath
	assign key_ctrl.advance = advance;
	assign key_ctrl.start   = start_s1;

	lakfc_key_unit u_key (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (key_ctrl),
		.seed_key (seed_key_q),
		.cipher   (cipher),
		.mask     (mask)
	);

	lakfc_codec u_codec (
		.direction   (direction_q),
		.letter_base (letter_base_q),
		.mask        (mask),
		.data_a      (data_a_s1),
		.data_b      (data_b_s1),
		.cipher      (cipher),
		.out_first   (res_first),
		.out_second  (res_second)
	);

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			first_s2  <= res_first;
			second_s2 <= res_second;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.out_first  = first_s2;
	assign rsp.out_second = second_s2;

	`ASSERT_HOLDS(a_accept_fills, clk, arst_n,
		(req.valid && req.ready) |=> valid_s1, "accepted item not staged")
	`ASSERT_NEVER(a_no_overrun, clk, arst_n,
		valid_s1 && valid_s2 && !rsp.ready && req.ready,
		"input taken while both stages stalled")
	`ASSERT_HOLDS(a_dec_second_zero, clk, arst_n,
		(valid_s2 && (direction_q == DIR_DECRYPT)) |-> (second_s2 == '0),
		"decrypt result has nonzero second field")
	`ASSERT_HOLDS(a_enc_digit_range, clk, arst_n,
		(valid_s2 && (direction_q == DIR_ENCRYPT)) |->
			(BYTE_W'(second_s2 - letter_base_q) < DIGIT_RADIX),
		"encrypt low digit out of range")

endmodule
